// ===== rtl/sptw_pkg.sv =====
// Package: shared types, codes and constants of the Sv39 page table walker
`timescale 1ns / 1ps
package sptw_pkg;

  localparam int SPTW_STORE_WORDS   = 4096;
  localparam int SPTW_VA_LIMIT_BITS = 38;

  localparam int TABLE_WORDS = 512;
  localparam int SLOT_W      = 9;
  localparam int PPN_W       = 44;
  localparam int PA_W        = 56;
  localparam int ROOT_W      = 3;
  localparam int CFG_IDX_W   = 1;

  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_USER   = 2'd1;
  localparam logic [1:0] OP_KERNEL = 2'd2;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_TOO_LARGE  = 3'd1;
  localparam logic [2:0] ST_NOT_MAPPED = 3'd2;
  localparam logic [2:0] ST_NOT_USER   = 3'd3;
  localparam logic [2:0] ST_OUTSIDE    = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_USER_ROOT   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_ROOT = 1'd1;

  localparam int PTE_V_BIT = 0;
  localparam int PTE_U_BIT = 4;
  localparam int PTE_PPN_LSB = 10;

  typedef struct packed {
    logic [1:0]  operation;
    logic [63:0] virt_addr;
    logic [11:0] store_index;
    logic [63:0] store_data;
  } in_req_t;

  typedef struct packed {
    logic [PA_W-1:0] phys_addr;
    logic [2:0]      status;
  } out_rsp_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_HOLD
  } state_t;

  typedef struct packed {
    logic       accept;
    logic       read;
    logic       finish;
    logic       use_leaf;
    logic [2:0] status;
    logic       flush;
  } dp_cmd_t;

  typedef struct packed {
    logic translate;
    logic va_big;
    logic root_out;
    logic entry_v;
    logic entry_u;
    logic ppn_out;
    logic level_zero;
    logic kernel;
    logic out_free;
  } dp_sts_t;

endpackage

// ===== rtl/sptw_ctrl.sv =====
// Walk controller: sequences table reads and result hand-off
`timescale 1ns / 1ps
module sptw_ctrl
  import sptw_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // command decode
  always_comb begin
    cmd      = '0;
    cmd.status = ST_OK;
    in_stall = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (!sts.translate) begin
            cmd.finish = 1'b1;
          end else if (sts.va_big) begin
            cmd.finish = 1'b1;
            cmd.status = ST_TOO_LARGE;
          end else if (sts.root_out) begin
            cmd.finish = 1'b1;
            cmd.status = ST_OUTSIDE;
          end else begin
            cmd.read = 1'b1;
          end
        end
      end
      S_WALK: begin
        if (!sts.entry_v) begin
          cmd.finish = 1'b1;
          cmd.status = ST_NOT_MAPPED;
        end else if (sts.level_zero) begin
          cmd.finish = 1'b1;
          if (!sts.kernel && !sts.entry_u) begin
            cmd.status = ST_NOT_USER;
          end else begin
            cmd.use_leaf = 1'b1;
          end
        end else if (sts.ppn_out) begin
          cmd.finish = 1'b1;
          cmd.status = ST_OUTSIDE;
        end else begin
          cmd.read = 1'b1;
        end
      end
      S_HOLD: begin
        cmd.flush = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE, S_WALK: begin
        if (cmd.read) begin
          state_nxt = S_WALK;
        end else if (cmd.finish) begin
          state_nxt = sts.out_free ? S_IDLE : S_HOLD;
        end
      end
      S_HOLD: begin
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/sptw_dp.sv =====
// Walk datapath: entry store, config roots, walk registers, result registers
`timescale 1ns / 1ps
module sptw_dp
  import sptw_pkg::*;
#(
  parameter int STORE_WORDS   = SPTW_STORE_WORDS,
  parameter int VA_LIMIT_BITS = SPTW_VA_LIMIT_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  in_req_t              in_req,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_rsp_t             out_rsp,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ROOT_W-1:0]    cfg_wdata,
  input  dp_cmd_t              cmd,
  output dp_sts_t              sts
);

  localparam int MEM_AW      = $clog2(STORE_WORDS);
  localparam int STORE_PAGES = STORE_WORDS / TABLE_WORDS;

  logic [63:0]       store_mem [STORE_WORDS];
  logic [63:0]       rdata_r;
  logic [ROOT_W-1:0] user_root_r, kernel_root_r;
  logic [63:0]       va_r, va_nxt;
  logic              kernel_r, kernel_nxt;
  logic [1:0]        level_r, level_nxt;
  out_rsp_t          res_r, res_nxt;
  out_rsp_t          out_r, out_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic [PPN_W-1:0]  root_page, ppn, rd_page;
  logic [63:0]       rd_va;
  logic [1:0]        rd_level;
  logic [SLOT_W-1:0] rd_slot;
  logic [PPN_W+SLOT_W-1:0] rd_word;
  logic              wr_en;
  logic [31:0]       wr_idx;
  out_rsp_t          fin_res;
  logic [PA_W-1:0]   leaf_pa;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      user_root_r   <= '0;
      kernel_root_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_USER_ROOT) begin
        user_root_r <= cfg_wdata;
      end
      if (cfg_index == CFG_KERNEL_ROOT) begin
        kernel_root_r <= cfg_wdata;
      end
    end
  end

  assign root_page = PPN_W'((in_req.operation == OP_KERNEL) ? kernel_root_r : user_root_r);
  assign ppn       = rdata_r[PTE_PPN_LSB +: PPN_W];

  assign sts.translate  = (in_req.operation == OP_USER) || (in_req.operation == OP_KERNEL);
  assign sts.va_big     = |in_req.virt_addr[63:VA_LIMIT_BITS];
  assign sts.root_out   = root_page >= PPN_W'(STORE_PAGES);
  assign sts.entry_v    = rdata_r[PTE_V_BIT];
  assign sts.entry_u    = rdata_r[PTE_U_BIT];
  assign sts.ppn_out    = ppn >= PPN_W'(STORE_PAGES);
  assign sts.level_zero = (level_r == 2'd0);
  assign sts.kernel     = kernel_r;
  assign sts.out_free   = !out_valid_r || !out_stall;

  // table read address
  assign rd_page  = cmd.accept ? root_page : ppn;
  assign rd_va    = cmd.accept ? in_req.virt_addr : va_r;
  assign rd_level = cmd.accept ? 2'd2 : level_r - 2'd1;

  always_comb begin
    case (rd_level)
      2'd2:    rd_slot = rd_va[30 +: SLOT_W];
      2'd1:    rd_slot = rd_va[21 +: SLOT_W];
      default: rd_slot = rd_va[12 +: SLOT_W];
    endcase
  end

  assign rd_word = {rd_page, rd_slot};

  assign wr_idx = 32'(in_req.store_index);
  assign wr_en  = cmd.accept && (in_req.operation == OP_WRITE) &&
                  (wr_idx < 32'(STORE_WORDS));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_mem[wr_idx[MEM_AW-1:0]] <= in_req.store_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      rdata_r <= store_mem[rd_word[MEM_AW-1:0]];
    end
  end

  // walk registers
  always_comb begin
    va_nxt     = va_r;
    kernel_nxt = kernel_r;
    level_nxt  = level_r;
    if (cmd.accept) begin
      va_nxt     = in_req.virt_addr;
      kernel_nxt = (in_req.operation == OP_KERNEL);
    end
    if (cmd.read) begin
      level_nxt = rd_level;
    end
  end

  always_ff @(posedge clk) begin
    va_r     <= va_nxt;
    kernel_r <= kernel_nxt;
    level_r  <= level_nxt;
  end

  // result
  assign leaf_pa = {ppn, 12'h000} | (kernel_r ? PA_W'(va_r[11:0]) : '0);

  always_comb begin
    fin_res.phys_addr = cmd.use_leaf ? leaf_pa : '0;
    fin_res.status    = cmd.use_leaf ? ST_OK : cmd.status;
  end

  always_comb begin
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.finish) begin
      if (sts.out_free) begin
        out_nxt       = fin_res;
        out_valid_nxt = 1'b1;
      end else begin
        res_nxt = fin_res;
      end
    end
    if (cmd.flush) begin
      out_nxt       = res_r;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_r;

endmodule

// ===== rtl/sv39_page_table_walker.sv =====
// Sv39 page table walker: top level joining controller and datapath
//
// Usage:
//   Requests enter on in_valid/in_stall/in_req. A write request stores
//   store_data at word store_index of the entry store (ignored past the
//   store size). A translate request walks three table levels from the
//   user or kernel root page, one store read per level. Results leave on
//   out_valid/out_stall/out_rsp, one per request. Root pages are set on
//   cfg_we/cfg_index/cfg_wdata while idle (the user's duty, unenforced).
// Sequence:
//   Writes and requests refused before the walk (address too large, root
//   outside the store) finish in the accept cycle. In a full walk the
//   accept cycle issues the level-2 read; evaluation cycles then check the
//   level-2, level-1 and level-0 entries in turn from the single-port
//   store, all but level 0 issuing the read below; reads are registered.
//   Early faults end it sooner. A decided result is registered in the
//   output or hold register. One request is in flight at a time.
// Reset clears the root pages, the controller and the output valid; the
// store contents stay undefined until written. A result finished behind a
// stalled output waits in a hold register and no new request is taken.
`timescale 1ns / 1ps
module sv39_page_table_walker
  import sptw_pkg::*;
#(
  parameter int STORE_WORDS   = SPTW_STORE_WORDS,
  parameter int VA_LIMIT_BITS = SPTW_VA_LIMIT_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_req_t              in_req,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_rsp_t             out_rsp,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ROOT_W-1:0]    cfg_wdata
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  sptw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  sptw_dp #(
    .STORE_WORDS   (STORE_WORDS),
    .VA_LIMIT_BITS (VA_LIMIT_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_rsp   (out_rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

// ===== rtl/sptw_checker.sv =====
// Port-level checker for the Sv39 page table walker, bound to the top level
`timescale 1ns / 1ps
module sptw_checker
  import sptw_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     out_valid,
  input logic     out_stall,
  input out_rsp_t out_rsp
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_rsp))
    else $error("stalled result changed");

  a_pa_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_rsp.status == ST_OK) || (out_rsp.phys_addr == '0))
    else $error("faulted result carries an address");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_rsp.status <= ST_OUTSIDE)
    else $error("undefined status code");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind sv39_page_table_walker sptw_checker u_sptw_checker (.*);
